>>> design/iitc_pkg.sv
// Shared types and constants for the integral image threshold counter.
// Used by iitc_front, iitc_back and the top level.
`default_nettype none

package iitc_pkg;

  // Fixed field widths
  localparam int unsigned CellW  = 16;
  localparam int unsigned RowW   = 32;
  localparam int unsigned SumW   = 36;
  localparam int unsigned CountW = 21;
  localparam int unsigned RwW    = 11;

  // Register indexes, decoded from the 8-byte register slot
  localparam logic RegRowWidth = 1'b0;
  localparam logic RegSumLimit = 1'b1;

  localparam logic [RwW-1:0]    RowWidthRst = 11'd1024;
  localparam logic [CountW-1:0] CountMax    = '1;

  // Per-item control that travels from the front to the back
  typedef struct packed {
    logic            sof;
    logic            first_row;
    logic [RowW-1:0] row_sum;
  } item_ctl_t;

endpackage

`default_nettype wire

>>> design/iitc_front.sv
// Front part: accepts cells, tracks column, row running sum and first-row flag.
// Depends on iitc_pkg.
`default_nettype none

module iitc_front
  import iitc_pkg::*;
#(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned VALUE_BITS = 16,
  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int unsigned WidW = $clog2(MAX_COLS + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [RwW-1:0]   row_width_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CellW-1:0] cell_value_i,
  input  wire logic             sof_i,
  output logic                  push_o,
  input  wire logic             full_i,
  output logic [ColW-1:0]       col_o,
  output item_ctl_t             ctl_o
);

  localparam int unsigned MaskW = (VALUE_BITS >= CellW) ? CellW : VALUE_BITS;
  localparam logic [CellW-1:0] ValMask = CellW'((32'd1 << MaskW) - 32'd1);

  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] rs_q, rs_d;
  logic            first_q, first_d;

  logic [ColW-1:0] col_base;
  logic [RowW-1:0] rs_base;
  logic            first_base;
  logic [RowW:0]   rs_sum;
  logic [RowW-1:0] rs_new;
  logic [WidW-1:0] eff_width;
  logic [WidW-1:0] col_next;
  logic            wrap;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Clamp a bad row width to the full line
  always_comb begin
    if (row_width_i == '0 || 32'(row_width_i) > MAX_COLS) begin
      eff_width = WidW'(MAX_COLS);
    end else begin
      eff_width = WidW'(row_width_i);
    end
  end

  // Start of frame restarts the row position
  assign col_base   = sof_i ? '0 : col_q;
  assign rs_base    = sof_i ? '0 : rs_q;
  assign first_base = sof_i ? 1'b1 : first_q;

  // Saturating row sum
  assign rs_sum = {1'b0, rs_base} + (RowW + 1)'(cell_value_i & ValMask);
  assign rs_new = rs_sum[RowW] ? '1 : rs_sum[RowW-1:0];

  assign col_next = WidW'(col_base) + WidW'(1);
  assign wrap     = col_next >= eff_width;

  assign col_o = col_base;
  assign ctl_o = '{sof: sof_i, first_row: first_base, row_sum: rs_new};

  // Advance position, clear on row wrap
  always_comb begin
    col_d   = col_q;
    rs_d    = rs_q;
    first_d = first_q;
    if (push_o) begin
      if (wrap) begin
        col_d   = '0;
        rs_d    = '0;
        first_d = 1'b0;
      end else begin
        col_d   = col_next[ColW-1:0];
        rs_d    = rs_new;
        first_d = first_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      rs_q    <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      rs_q    <= rs_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

>>> design/iitc_queue.sv
// Two-entry queue between the front and the back.
// Depends on nothing outside itself.
`default_nettype none

module iitc_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      pop_data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/iitc_back.sv
// Back part: line store read, corner sum, limit compare, hit count, output register.
// Depends on iitc_pkg.
`default_nettype none

module iitc_back
  import iitc_pkg::*;
#(
  parameter int unsigned MAX_COLS = 1024,
  localparam int unsigned ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SumW-1:0]   sum_limit_i,
  input  wire logic              q_valid_i,
  output logic                   pop_o,
  input  wire logic [ColW-1:0]   col_i,
  input  wire item_ctl_t         ctl_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SumW-1:0]        corner_sum_o,
  output logic                   within_limit_o,
  output logic [CountW-1:0]      count_so_far_o
);

  // Line store of the previous row's corner sums
  logic [SumW-1:0] line_mem [MAX_COLS];
  logic [SumW-1:0] rd_q;

  // Compute stage
  logic            c_valid_q;
  logic [ColW-1:0] c_col_q;
  item_ctl_t       c_ctl_q;
  logic            c_adv;

  // Last write, for same-column bypass
  logic            w_valid_q;
  logic [ColW-1:0] w_col_q;
  logic [SumW-1:0] w_sum_q;

  logic [CountW-1:0] cnt_q;

  logic              out_valid_q;
  logic [SumW-1:0]   out_sum_q;
  logic              out_hit_q;
  logic [CountW-1:0] out_cnt_q;

  logic [SumW-1:0]   prior;
  logic [SumW:0]     sum_full;
  logic [SumW-1:0]   corner;
  logic              hit;
  logic [CountW-1:0] cnt_base;
  logic [CountW-1:0] cnt_new;

  assign c_adv = c_valid_q && (!out_valid_q || out_ready_i);
  assign pop_o = q_valid_i && (!c_valid_q || c_adv);

  // Take the just-written sum when the read raced the write
  assign prior    = (w_valid_q && w_col_q == c_col_q) ? w_sum_q : rd_q;
  assign sum_full = {1'b0, prior} + (SumW + 1)'(c_ctl_q.row_sum);

  always_comb begin
    if (c_ctl_q.first_row) begin
      corner = SumW'(c_ctl_q.row_sum);
    end else if (sum_full[SumW]) begin
      corner = '1;
    end else begin
      corner = sum_full[SumW-1:0];
    end
  end

  assign hit      = corner <= sum_limit_i;
  assign cnt_base = c_ctl_q.sof ? '0 : cnt_q;
  assign cnt_new  = (hit && cnt_base != CountMax) ? cnt_base + CountW'(1) : cnt_base;

  // Read line store on pop
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q <= line_mem[col_i];
    end
  end

  // Write corner sum back on advance
  always_ff @(posedge clk_i) begin
    if (c_adv) begin
      line_mem[c_col_q] <= corner;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      c_col_q <= col_i;
      c_ctl_q <= ctl_i;
    end
    if (c_adv) begin
      w_col_q   <= c_col_q;
      w_sum_q   <= corner;
      out_sum_q <= corner;
      out_hit_q <= hit;
      out_cnt_q <= cnt_new;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (pop_o) begin
        c_valid_q <= 1'b1;
      end else if (c_adv) begin
        c_valid_q <= 1'b0;
      end
      if (c_adv) begin
        w_valid_q   <= 1'b1;
        cnt_q       <= cnt_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign corner_sum_o   = out_sum_q;
  assign within_limit_o = out_hit_q;
  assign count_so_far_o = out_cnt_q;

endmodule

`default_nettype wire

>>> design/integral_image_threshold_count.sv
// Top level of the integral image threshold counter: APB registers, stream ports.
// Depends on iitc_pkg, iitc_front, iitc_queue and iitc_back.
//
// Channel   | Dir | Handshake                  | Payload
// s_axis    | in  | s_axis_tvalid/tready       | tdata: cell_value; tuser: start_of_frame
// m_axis    | out | m_axis_tvalid/tready       | tdata: corner_sum, within_limit, count_so_far
// apb       | in  | psel, penable, pwrite      | row_width @0x0, sum_limit @0x8
//
// One cell per cycle sustained while m_axis_tready stays high; a taken cell goes through
// queue entry, line store read, then corner add and compare into the output register.
// The line store has one read port and one write port; a same-column bypass covers
// short rows. Reset needs no clearing pass. A stalled output fills the two-entry
// queue, then s_axis_tready drops.
`default_nettype none

module integral_image_threshold_count
  import iitc_pkg::*;
#(
  parameter int unsigned MAX_COLS   = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [15:0] cell_value
  input  wire logic        s_axis_tuser_i,  // [0] start_of_frame
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,  // [35:0] corner_sum, [36] within_limit,
                                            // [57:37] count_so_far, [63:58] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int unsigned ColW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned QDataW = ColW + $bits(item_ctl_t);

  logic [RwW-1:0]  row_width_q;
  logic [SumW-1:0] sum_limit_q;
  logic            cfg_wr;

  logic              push;
  logic              full;
  logic [ColW-1:0]   f_col;
  item_ctl_t         f_ctl;
  logic              q_valid;
  logic              pop;
  logic [QDataW-1:0] q_data;
  logic [SumW-1:0]   corner_sum;
  logic              within_limit;
  logic [CountW-1:0] count_so_far;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthRst;
      sum_limit_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        RegRowWidth: row_width_q <= pwdata[RwW-1:0];
        RegSumLimit: sum_limit_q <= pwdata[SumW-1:0];
        default:     ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3])
      RegRowWidth: prdata = 64'(row_width_q);
      RegSumLimit: prdata = 64'(sum_limit_q);
      default:     prdata = '0;
    endcase
  end

  iitc_front #(
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_width_i  (row_width_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .cell_value_i (s_axis_tdata_i),
    .sof_i        (s_axis_tuser_i),
    .push_o       (push),
    .full_i       (full),
    .col_o        (f_col),
    .ctl_o        (f_ctl)
  );

  iitc_queue #(
    .DATA_W (QDataW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_col, f_ctl}),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  iitc_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sum_limit_i    (sum_limit_q),
    .q_valid_i      (q_valid),
    .pop_o          (pop),
    .col_i          (q_data[QDataW-1 -: ColW]),
    .ctl_i          (q_data[$bits(item_ctl_t)-1:0]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .corner_sum_o   (corner_sum),
    .within_limit_o (within_limit),
    .count_so_far_o (count_so_far)
  );

  // Pack the result beat
  assign m_axis_tdata_o = {6'b0, count_so_far, within_limit, corner_sum};

endmodule

`default_nettype wire
